### rtl/als_pkg.sv
package als_pkg;

    // fixed widths of the channel fields
    localparam int MODE_W    = 2;
    localparam int KEY_IN_W  = 32;
    localparam int SLOT_IN_W = 4;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_ALLOC_WR,
        S_FREE_CHK,
        S_FREE_RD,
        S_FREE_LINK,
        S_FREE_CLOSE,
        S_SRCH_FIRST,
        S_SRCH_CMP,
        S_DONE
    } als_state_t;

endpackage

### rtl/als_if.sv
interface als_req_if;
    import als_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [MODE_W-1:0]           mode;
    logic signed [KEY_IN_W-1:0]  key;
    logic [SLOT_IN_W-1:0]        slot_index;

    modport source (output valid, output mode, output key, output slot_index, input ready);
    modport sink   (input valid, input mode, input key, input slot_index, output ready);
endinterface

interface als_rsp_if;
    import als_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SLOT_IN_W-1:0]  result_slot;
    logic [STATUS_W-1:0]   status;
    logic [OCC_W-1:0]      occupancy;

    modport source (output valid, output result_slot, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input result_slot, input status, input occupancy,
                    output ready);
endinterface

### rtl/array_list_slot_allocator.sv
// slot allocator: a ring of LIST_LENGTH+1 slots kept as a doubly linked list in
// block memories, with the free run starting at the free head.
// req carries one word per operation (mode, key, slot_index); rsp returns one
// word per operation (result_slot, status, occupancy), in order.
// after reset the block runs a clearing pass over all LIST_LENGTH+1 slots that
// writes the initial links and clears the in-use flags; req.ready stays low
// during the pass.
// operations run one at a time. allocate passes S_START, S_ALLOC_WR and S_DONE
// (S_START and S_DONE when full); free passes S_START, S_FREE_CHK, S_FREE_RD,
// S_FREE_LINK, S_FREE_CLOSE and S_DONE, stopping after S_FREE_CHK for a slot
// not in use or for the free head and after S_START for a slot index beyond the
// ring; search passes S_START, S_SRCH_FIRST and one S_SRCH_CMP per slot walked
// (S_START and S_DONE on an empty list); unknown modes pass S_START and S_DONE.
// the next word is taken the cycle after the result is loaded.
// the walk reads one link and one key per cycle, and free needs a read of the
// old free head's back link after the unlink.
// the result sits in an output register: a new word is accepted while it
// waits, but a finished operation holds until rsp.ready drains that register.
module array_list_slot_allocator #(
    parameter int LIST_LENGTH = 15,
    parameter int KEY_WIDTH   = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    als_req_if.sink   req,
    als_rsp_if.source rsp
);
    import als_pkg::*;

    localparam int SLOTS = LIST_LENGTH + 1;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = ((IDX_W > SLOT_IN_W) ? IDX_W : SLOT_IN_W) + 1;
    localparam int KW1   = KEY_WIDTH + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    als_state_t state_reg, state_next;

    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     p_reg, p_next;
    logic [MODE_W-1:0]    mode_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [SLOT_IN_W-1:0] idx_reg;
    logic [IDX_W-1:0]     res_slot_reg, res_slot_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;

    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_IN_W-1:0] out_slot_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [OCC_W-1:0]     out_occ_reg;

    // memory ports
    logic             nx_we, pv_we, ky_we;
    logic [IDX_W-1:0] nx_waddr, pv_waddr, ky_waddr;
    logic [IDX_W-1:0] nx_wdata, pv_wdata;
    logic [KW1-1:0]   ky_wdata;
    logic [IDX_W-1:0] nx_raddr, pv_raddr, ky_raddr;
    logic [IDX_W-1:0] nx_rdata, pv_rdata;
    logic [KW1-1:0]   ky_rdata;

    logic             accept;
    logic             full;
    logic             idx_bad;
    logic [IDX_W-1:0] n_idx;
    logic             slot_used;
    logic             key_hit;
    logic             srch_last;
    logic             out_load;

    assign accept    = req.valid && req.ready;
    assign full      = (used_reg == CNT_W'(SLOTS));
    assign idx_bad   = (CMP_W'(idx_reg) >= CMP_W'(SLOTS));
    assign n_idx     = IDX_W'(idx_reg);
    assign slot_used = ky_rdata[KEY_WIDTH];
    assign key_hit   = (ky_rdata[KEY_WIDTH-1:0] == key_reg);
    assign srch_last = (CNT_W'(count_reg + 1'b1) == used_reg);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.result_slot = out_slot_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.occupancy   = out_occ_reg;

    als_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (nx_raddr),
        .rdata (nx_rdata)
    );

    als_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (pv_raddr),
        .rdata (pv_rdata)
    );

    // in-use flag on top of the stored key
    als_ram #(.WIDTH(KW1), .DEPTH(SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (ky_we),
        .waddr (ky_waddr),
        .wdata (ky_wdata),
        .raddr (ky_raddr),
        .rdata (ky_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                unique case (mode_reg)
                    MODE_ALLOC:  state_next = full ? S_DONE : S_ALLOC_WR;
                    MODE_FREE:   state_next = idx_bad ? S_DONE : S_FREE_CHK;
                    MODE_SEARCH: state_next = (used_reg == '0) ? S_DONE : S_SRCH_FIRST;
                    default:     state_next = S_DONE;
                endcase
            end
            S_ALLOC_WR:
            begin
                state_next = S_DONE;
            end
            S_FREE_CHK:
            begin
                if (!slot_used || n_idx == head_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FREE_RD;
                end
            end
            S_FREE_RD:    state_next = S_FREE_LINK;
            S_FREE_LINK:  state_next = S_FREE_CLOSE;
            S_FREE_CLOSE: state_next = S_DONE;
            S_SRCH_FIRST: state_next = S_SRCH_CMP;
            S_SRCH_CMP:
            begin
                if (key_hit || srch_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        clr_next        = clr_reg;
        head_next       = head_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        p_next          = p_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;

        nx_we    = 1'b0;
        nx_waddr = head_reg;
        nx_wdata = head_reg;
        nx_raddr = head_reg;
        pv_we    = 1'b0;
        pv_waddr = head_reg;
        pv_wdata = head_reg;
        pv_raddr = head_reg;
        ky_we    = 1'b0;
        ky_waddr = head_reg;
        ky_wdata = {1'b1, key_reg};
        ky_raddr = head_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                nx_we    = 1'b1;
                nx_waddr = clr_reg;
                nx_wdata = (clr_reg == LAST_IDX) ? '0 : IDX_W'(clr_reg + 1'b1);
                pv_we    = 1'b1;
                pv_waddr = clr_reg;
                pv_wdata = (clr_reg == '0) ? LAST_IDX : IDX_W'(clr_reg - 1'b1);
                ky_we    = 1'b1;
                ky_waddr = clr_reg;
                ky_wdata = '0;
                clr_next = IDX_W'(clr_reg + 1'b1);
            end
            S_START:
            begin
                res_slot_next   = '0;
                res_status_next = ST_OK;
                nx_raddr        = head_reg;
                pv_raddr        = head_reg;
                count_next      = '0;
                unique case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (full)
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    MODE_FREE:
                    begin
                        nx_raddr = n_idx;
                        pv_raddr = n_idx;
                        ky_raddr = n_idx;
                        if (idx_bad)
                        begin
                            res_status_next = ST_UNUSED;
                        end
                    end
                    MODE_SEARCH:
                    begin
                        if (used_reg == '0)
                        begin
                            res_status_next = ST_MISS;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_ALLOC_WR:
            begin
                // next link of the free head becomes the new head
                pv_we         = 1'b1;
                pv_waddr      = nx_rdata;
                pv_wdata      = head_reg;
                ky_we         = 1'b1;
                ky_waddr      = head_reg;
                ky_wdata      = {1'b1, key_reg};
                head_next     = nx_rdata;
                used_next     = CNT_W'(used_reg + 1'b1);
                res_slot_next = head_reg;
            end
            S_FREE_CHK:
            begin
                if (!slot_used)
                begin
                    res_status_next = ST_UNUSED;
                end
                else
                begin
                    ky_we         = 1'b1;
                    ky_waddr      = n_idx;
                    ky_wdata      = '0;
                    used_next     = CNT_W'(used_reg - 1'b1);
                    res_slot_next = n_idx;
                    if (n_idx != head_reg)
                    begin
                        // unlink: next[prev] = next, prev[next] = prev
                        nx_we    = 1'b1;
                        nx_waddr = pv_rdata;
                        nx_wdata = nx_rdata;
                        pv_we    = 1'b1;
                        pv_waddr = nx_rdata;
                        pv_wdata = pv_rdata;
                    end
                end
            end
            S_FREE_RD:
            begin
                pv_raddr = head_reg;
            end
            S_FREE_LINK:
            begin
                // tail of the used run now links forward to the freed slot
                nx_we    = 1'b1;
                nx_waddr = pv_rdata;
                nx_wdata = n_idx;
                pv_we    = 1'b1;
                pv_waddr = n_idx;
                pv_wdata = pv_rdata;
            end
            S_FREE_CLOSE:
            begin
                pv_we     = 1'b1;
                pv_waddr  = head_reg;
                pv_wdata  = n_idx;
                nx_we     = 1'b1;
                nx_waddr  = n_idx;
                nx_wdata  = head_reg;
                head_next = n_idx;
            end
            S_SRCH_FIRST:
            begin
                // newest used slot, fetch its key and back link together
                p_next   = pv_rdata;
                pv_raddr = pv_rdata;
                ky_raddr = pv_rdata;
            end
            S_SRCH_CMP:
            begin
                if (key_hit)
                begin
                    res_slot_next = p_reg;
                end
                else if (srch_last)
                begin
                    res_status_next = ST_MISS;
                end
                else
                begin
                    count_next = CNT_W'(count_reg + 1'b1);
                    p_next     = pv_rdata;
                    pv_raddr   = pv_rdata;
                    ky_raddr   = pv_rdata;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            head_reg       <= '0;
            used_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            head_reg       <= head_next;
            used_reg       <= used_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        if (accept)
        begin
            mode_reg <= req.mode;
            key_reg  <= KEY_WIDTH'(req.key);
            idx_reg  <= req.slot_index;
        end
        if (out_load)
        begin
            out_slot_reg   <= SLOT_IN_W'(res_slot_reg);
            out_status_reg <= res_status_reg;
            out_occ_reg    <= OCC_W'(used_reg);
        end
    end

endmodule

### rtl/als_ram.sv
module als_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### verif/array_list_slot_allocator_tb.sv
`timescale 1ns / 1ps

module array_list_slot_allocator_tb;
    import als_pkg::*;

    localparam int SLOTS       = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_OPS   = 210;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic signed [KEY_IN_W-1:0] key;
        logic [SLOT_IN_W-1:0]       slot_index;
    } slot_op_t;

    typedef struct packed {
        logic [SLOT_IN_W-1:0] result_slot;
        logic [STATUS_W-1:0]  status;
        logic [OCC_W-1:0]     occupancy;
    } slot_reply_t;

    logic clk;
    logic rst_n;

    als_req_if req_if();
    als_rsp_if rsp_if();

    array_list_slot_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // predicted ring state, advanced as words are queued
    logic [3:0]          ring_next [SLOTS];
    logic [3:0]          ring_prev [SLOTS];
    logic [KEY_IN_W-1:0] ring_key  [SLOTS];
    logic                ring_busy [SLOTS];
    logic [3:0]          ring_head;
    int                  ring_count;

    slot_op_t    op_queue[$];
    slot_reply_t pending_replies[$];
    slot_op_t    next_op;
    slot_reply_t expected_reply;

    int ops_pushed;
    int ops_taken;
    int fault_count;
    int quiet_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_token;
    int hold_seen;
    int hold_left;
    int peak_occupancy;
    int mode_count [4];
    int status_count [4];
    logic req_taken;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic slot_reply_t predict_slot_op(slot_op_t op);
        slot_reply_t r;
        logic [3:0]  n;
        logic [3:0]  f;
        logic [3:0]  a;
        logic [3:0]  b;
        logic [3:0]  tail;
        logic [3:0]  p;
        bit          hit;
        r.result_slot = '0;
        r.status      = ST_OK;
        f = ring_head;
        case (op.mode)
            MODE_ALLOC:
            begin
                if (ring_count >= SLOTS)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    ring_key[f]            = op.key;
                    ring_busy[f]           = 1'b1;
                    ring_prev[ring_next[f]] = f;
                    ring_head              = ring_next[f];
                    ring_count++;
                    r.result_slot = f;
                end
            end
            MODE_FREE:
            begin
                n = op.slot_index;
                if (!ring_busy[n])
                begin
                    r.status = ST_UNUSED;
                end
                else
                begin
                    // the free head itself only loses its busy mark
                    if (n != f)
                    begin
                        a = ring_prev[n];
                        b = ring_next[n];
                        ring_next[a] = b;
                        ring_prev[b] = a;
                        tail = ring_prev[f];
                        ring_next[tail] = n;
                        ring_prev[n]    = tail;
                        ring_prev[f]    = n;
                        ring_next[n]    = f;
                        ring_head       = n;
                    end
                    ring_busy[n] = 1'b0;
                    if (ring_count > 0)
                        ring_count--;
                    r.result_slot = n;
                end
            end
            MODE_SEARCH:
            begin
                p   = f;
                hit = 1'b0;
                // newest first: walk back from the free head
                for (int i = 0; i < ring_count && !hit; i++)
                begin
                    p = ring_prev[p];
                    if (ring_key[p] == op.key)
                        hit = 1'b1;
                end
                if (hit)
                    r.result_slot = p;
                else
                    r.status = ST_MISS;
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(ring_count);
        return r;
    endfunction

    task automatic queue_op(input slot_op_t op);
        slot_reply_t r;
        r = predict_slot_op(op);
        op_queue.push_back(op);
        pending_replies.push_back(r);
        ops_pushed++;
        mode_count[op.mode]++;
        status_count[r.status]++;
        if (r.occupancy > peak_occupancy)
            peak_occupancy = r.occupancy;
    endtask

    task automatic queue_random_op(input bit filling);
        slot_op_t op;
        int       roll;
        int       busy[$];
        op.key        = $urandom;
        op.slot_index = SLOT_IN_W'($urandom_range(SLOTS - 1));
        for (int i = 0; i < SLOTS; i++)
            if (ring_busy[i])
                busy.push_back(i);
        roll = $urandom_range(99);
        if (roll < 4)
        begin
            op.mode = MODE_SPARE;
        end
        else if (roll < (filling ? 60 : 20))
        begin
            op.mode = MODE_ALLOC;
            // a small pool of keys so that duplicates turn up
            if ($urandom_range(99) < 40)
                case ($urandom_range(5))
                    0:       op.key = 32'sh0;
                    1:       op.key = -32'sd1;
                    2:       op.key = 32'sh80000000;
                    3:       op.key = 32'sh7fffffff;
                    default: op.key = $urandom_range(7);
                endcase
        end
        else if (roll < 74)
        begin
            op.mode = MODE_FREE;
            if (busy.size() != 0 && $urandom_range(99) < 85)
                op.slot_index = SLOT_IN_W'(busy[$urandom_range(busy.size() - 1)]);
        end
        else
        begin
            op.mode = MODE_SEARCH;
            if (busy.size() != 0 && $urandom_range(99) < 75)
                op.key = ring_key[busy[$urandom_range(busy.size() - 1)]];
        end
        queue_op(op);
    endtask

    // driver: a new word goes out once the previous one has been taken
    always @(negedge clk)
    begin
        if (rst_n && (!req_if.valid || req_taken))
        begin
            if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_op = op_queue.pop_front();
                req_if.valid      <= 1'b1;
                req_if.mode       <= next_op.mode;
                req_if.key        <= next_op.key;
                req_if.slot_index <= next_op.slot_index;
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // receiver ready, with a long hold-off whenever the token moves
    always @(negedge clk)
    begin
        if (hold_seen != hold_token)
        begin
            hold_seen    <= hold_token;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        req_taken <= req_if.valid && req_if.ready;
        if (req_if.valid && req_if.ready)
            ops_taken <= ops_taken + 1;
        if (rsp_if.valid && rsp_if.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected reply: slot %0d status %0d occupancy %0d",
                             rsp_if.result_slot, rsp_if.status, rsp_if.occupancy);
                fault_count++;
            end
            else
            begin
                expected_reply = pending_replies.pop_front();
                if (rsp_if.result_slot !== expected_reply.result_slot ||
                    rsp_if.status      !== expected_reply.status ||
                    rsp_if.occupancy   !== expected_reply.occupancy)
                begin
                    if (fault_count < 10)
                        $display({"mismatch at %0t: slot %0d/%0d status %0d/%0d ",
                                  "occupancy %0d/%0d (expected/actual)"},
                                 $realtime, expected_reply.result_slot, rsp_if.result_slot,
                                 expected_reply.status, rsp_if.status,
                                 expected_reply.occupancy, rsp_if.occupancy);
                    fault_count++;
                end
            end
        end
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d replies outstanding",
                     QUIET_LIMIT, pending_replies.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int send_pct [4];
        int recv_pct [4];
        slot_op_t op;
        send_pct = '{0, 88, 0, 26};
        recv_pct = '{0, 0, 88, 26};

        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.mode       = MODE_ALLOC;
        req_if.key        = '0;
        req_if.slot_index = '0;
        rsp_if.ready      = 1'b0;
        req_taken         = 1'b0;
        ops_pushed        = 0;
        ops_taken         = 0;
        fault_count       = 0;
        quiet_cycles      = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_token        = 0;
        hold_seen         = 0;
        hold_left         = 0;
        peak_occupancy    = 0;
        for (int i = 0; i < 4; i++)
        begin
            mode_count[i]   = 0;
            status_count[i] = 0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            ring_next[i] = 4'((i + 1) % SLOTS);
            ring_prev[i] = 4'((i + SLOTS - 1) % SLOTS);
            ring_key[i]  = '0;
            ring_busy[i] = 1'b0;
        end
        ring_head  = '0;
        ring_count = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: empty list, spare mode, fill to full, head free when full
        op = '{mode: MODE_SEARCH, key: 32'sh0, slot_index: 4'd0};
        queue_op(op);
        op = '{mode: MODE_FREE, key: 32'sh0, slot_index: 4'd5};
        queue_op(op);
        op = '{mode: MODE_SPARE, key: -32'sd1, slot_index: 4'd15};
        queue_op(op);
        for (int i = 0; i < SLOTS; i++)
        begin
            op.mode       = MODE_ALLOC;
            op.slot_index = SLOT_IN_W'($urandom_range(SLOTS - 1));
            case (i)
                0:       op.key = 32'sh7fffffff;
                1:       op.key = 32'sh80000000;
                2:       op.key = -32'sd1;
                3:       op.key = 32'sh0;
                4, 5:    op.key = 32'sd5;
                default: op.key = $urandom;
            endcase
            queue_op(op);
        end
        op = '{mode: MODE_ALLOC, key: 32'sd9, slot_index: 4'd0};
        queue_op(op);
        op = '{mode: MODE_SEARCH, key: 32'sd5, slot_index: 4'd0};
        queue_op(op);
        op = '{mode: MODE_FREE, key: 32'sh0, slot_index: 4'd0};
        queue_op(op);
        op = '{mode: MODE_FREE, key: 32'sh0, slot_index: 4'd15};
        queue_op(op);
        op = '{mode: MODE_SEARCH, key: 32'sh80000000, slot_index: 4'd15};
        queue_op(op);
        op = '{mode: MODE_FREE, key: 32'sh0, slot_index: 4'd0};
        queue_op(op);

        for (int ph = 0; ph <= 4; ph++)
        begin
            while (ops_taken != ops_pushed || pending_replies.size() != 0)
                @(negedge clk);
            @(posedge clk);
            if (ph < 4)
            begin
                send_idle_pct  = send_pct[ph];
                recv_stall_pct = recv_pct[ph];
                // swing between filling and draining so every occupancy comes up
                for (int i = 0; i < PHASE_OPS; i++)
                    queue_random_op(((i / 45) % 2) == 0);
            end
            else
            begin
                // receiver holds off while the sender keeps offering words
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                hold_token     = hold_token + 1;
                for (int i = 0; i < 40; i++)
                    queue_random_op(1'b1);
            end
        end

        while (ops_taken != ops_pushed || pending_replies.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        fault_count += pending_replies.size();

        $display("run covered %0d allocates, %0d frees, %0d searches, %0d spare-mode words",
                 mode_count[MODE_ALLOC], mode_count[MODE_FREE], mode_count[MODE_SEARCH],
                 mode_count[MODE_SPARE]);
        $display("full %0d, not in use %0d, search misses %0d, peak occupancy %0d, failures %0d",
                 status_count[ST_FULL], status_count[ST_UNUSED], status_count[ST_MISS],
                 peak_occupancy, fault_count);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
